// ===== hdl/phase_control_dimmer_macros.svh =====
// Assertion macros for the phase-control dimmer.
// Used by the top level; empty when SYNTHESIS is defined.
`ifndef PHASE_CONTROL_DIMMER_MACROS_SVH
`define PHASE_CONTROL_DIMMER_MACROS_SVH
`ifndef SYNTHESIS
`define PCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcd assertion failed");
`define PCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcd assertion failed");
`else
`define PCD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/pcd_pkg.sv =====
// Shared constants for the phase-control dimmer: event codes, register
// indexes, level and key thresholds, and the firing-angle curve.
`default_nettype none

package pcd_pkg;

    localparam int LEVEL_W = 7;
    localparam int TEMP_W  = 8;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 8;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ZCROSS = 2'd1;
    localparam logic [1:0] OP_KEY    = 2'd2;
    localparam logic [1:0] OP_SENSOR = 2'd3;

    localparam logic [CFG_AW-1:0] REG_LEVEL_MAX  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LEVEL_MIN  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_START_LVL  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TEMP_HIGH  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_TEMP_LOW   = 3'd4;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 7'd100;
    localparam logic [7:0] KEY_SHORT     = 8'd3;
    localparam logic [7:0] KEY_LATCH_LO  = 8'd20;
    localparam logic [7:0] KEY_LONG      = 8'd25;

    localparam logic [7:0] CURVE [0:99] = '{
        8'h03, 8'h08, 8'h0B, 8'h0E, 8'h11, 8'h13, 8'h16, 8'h18, 8'h1A, 8'h1C,
        8'h1E, 8'h20, 8'h22, 8'h24, 8'h26, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2E,
        8'h30, 8'h32, 8'h33, 8'h35, 8'h37, 8'h38, 8'h3A, 8'h3B, 8'h3D, 8'h3F,
        8'h40, 8'h42, 8'h43, 8'h45, 8'h46, 8'h48, 8'h49, 8'h4B, 8'h4C, 8'h4E,
        8'h4F, 8'h51, 8'h52, 8'h54, 8'h55, 8'h57, 8'h58, 8'h5A, 8'h5B, 8'h5D,
        8'h5E, 8'h60, 8'h61, 8'h63, 8'h65, 8'h66, 8'h68, 8'h69, 8'h6B, 8'h6C,
        8'h6E, 8'h70, 8'h71, 8'h73, 8'h75, 8'h76, 8'h78, 8'h7A, 8'h7C, 8'h7D,
        8'h7F, 8'h81, 8'h83, 8'h85, 8'h87, 8'h88, 8'h8A, 8'h8C, 8'h8F, 8'h91,
        8'h93, 8'h95, 8'h97, 8'h9A, 8'h9C, 8'h9F, 8'hA1, 8'hA4, 8'hA7, 8'hAA,
        8'hAD, 8'hB0, 8'hB4, 8'hB7, 8'hBC, 8'hC0, 8'hC6, 8'hCC, 8'hD4, 8'hFF
    };

    function automatic logic [7:0] f_curve(input logic [LEVEL_W-1:0] lvl);
        logic [7:0] res;
        res = 8'hFF;
        if (lvl < FULL_LEVEL) begin
            res = CURVE[lvl];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/phase_control_dimmer.sv =====
// Phase-control dimmer: one event item in, one status item out.
// Input register, then result register; one item per cycle when not stalled.
// The firing delay is an 8x8 multiply by the curve entry and a divide by 255.
// o_stall drops whenever the result register is free or being taken.
// Synchronous active-low reset restores the register defaults and dimmer state.
// Depends on pcd_pkg and phase_control_dimmer_macros.svh.
`default_nettype none
`include "phase_control_dimmer_macros.svh"

module phase_control_dimmer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [pcd_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [pcd_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_opcode,
    input  wire logic                        i_key_down,
    input  wire logic [7:0]                  i_press_time,
    input  wire logic                        i_sensor_fault,
    input  wire logic [pcd_pkg::TEMP_W-1:0]  i_temperature,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_triac_drive,
    output logic                             o_is_on,
    output logic                             o_awaiting_sync,
    output logic                             o_is_fault,
    output logic [pcd_pkg::LEVEL_W-1:0]      o_current_level,
    output logic                             o_save_request
);
    import pcd_pkg::*;

    logic [LEVEL_W-1:0] r_level_max, r_level_min, r_start_level;
    logic [TEMP_W-1:0]  r_temp_high, r_temp_low;

    logic               r_in_valid;
    logic [1:0]         r_in_op;
    logic               r_in_down;
    logic [7:0]         r_in_press;
    logic               r_in_hwf;
    logic [TEMP_W-1:0]  r_in_temp;

    logic [7:0]         r_half_period, n_half_period;
    logic [7:0]         r_phase_delay, n_phase_delay;
    logic [7:0]         r_timer_cnt, n_timer_cnt;
    logic               r_timer_run, n_timer_run;
    logic               r_ovf_armed, n_ovf_armed;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [LEVEL_W-1:0] r_ramp_base, n_ramp_base;
    logic               r_on, n_on;
    logic               r_sync_wait, n_sync_wait;
    logic               r_fault, n_fault;
    logic               r_gate, n_gate;
    logic               n_save;

    logic               r_out_valid;
    logic               r_out_gate, r_out_on, r_out_sync, r_out_fault, r_out_save;
    logic [LEVEL_W-1:0] r_out_level;

    logic               advance;
    logic               load_in;

    logic [7:0]         tick_cnt;
    logic [7:0]         zc_half;
    logic [15:0]        zc_prod;
    logic [16:0]        zc_div;
    logic [7:0]         zc_delay;
    logic [7:0]         key_step;
    logic [8:0]         ramp_up;
    logic [8:0]         ramp_floor;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign load_in = !r_in_valid || advance;
    assign o_stall = !load_in;

    always_comb begin
        n_half_period = r_half_period;
        n_phase_delay = r_phase_delay;
        n_timer_cnt   = r_timer_cnt;
        n_timer_run   = r_timer_run;
        n_ovf_armed   = r_ovf_armed;
        n_level       = r_level;
        n_ramp_base   = r_ramp_base;
        n_on          = r_on;
        n_sync_wait   = r_sync_wait;
        n_fault       = r_fault;
        n_gate        = r_gate;
        n_save        = 1'b0;

        tick_cnt   = r_timer_cnt + 8'd1;
        zc_half    = r_phase_delay + r_timer_cnt;
        zc_prod    = {8'd0, zc_half} * {8'd0, f_curve(r_level)};
        zc_div     = {1'b0, zc_prod} + {9'd0, zc_prod[15:8]} + 17'd1;
        zc_delay   = zc_div[15:8];
        key_step   = r_in_press - KEY_LONG;
        ramp_up    = {2'b00, r_ramp_base} + {1'b0, key_step};
        ramp_floor = {2'b00, r_level_min} + {1'b0, key_step};

        case (r_in_op)
            OP_TICK: begin
                if (r_timer_run) begin
                    n_timer_cnt = tick_cnt;
                    if (tick_cnt == 8'd0 && r_ovf_armed && r_on) begin
                        if (r_sync_wait) begin
                            n_gate        = 1'b0;
                            n_timer_run   = 1'b0;
                            n_ovf_armed   = 1'b0;
                            n_timer_cnt   = 8'd0;
                            n_half_period = 8'd0;
                        end else begin
                            n_gate      = 1'b1;
                            n_sync_wait = 1'b1;
                        end
                    end
                end
            end
            OP_ZCROSS: begin
                n_timer_run = 1'b0;
                n_ovf_armed = 1'b0;
                n_sync_wait = 1'b0;
                n_gate      = 1'b0;
                if (r_on && !r_fault) begin
                    n_half_period = zc_half;
                    n_timer_run   = 1'b1;
                    if (r_level >= FULL_LEVEL) begin
                        n_phase_delay = 8'd0;
                        n_timer_cnt   = 8'd0;
                        n_gate        = 1'b1;
                    end else if (zc_half != 8'd0) begin
                        n_phase_delay = zc_delay;
                        n_timer_cnt   = zc_half - zc_delay;
                        n_ovf_armed   = 1'b1;
                    end else begin
                        n_timer_cnt = 8'd0;
                    end
                end else begin
                    n_half_period = 8'd0;
                end
            end
            OP_KEY: begin
                if (r_on) begin
                    if (r_fault) begin
                        if (r_in_press > KEY_SHORT) begin
                            n_on = 1'b0;
                        end
                    end else if (r_in_down) begin
                        if (r_in_press > KEY_LATCH_LO && r_in_press < KEY_LONG) begin
                            n_ramp_base = r_level;
                        end else if (r_in_press > KEY_LONG) begin
                            if (r_ramp_base < r_level_max) begin
                                if (ramp_up >= {2'b00, r_level_max}) begin
                                    n_level = r_level_max;
                                end else begin
                                    n_level = ramp_up[LEVEL_W-1:0];
                                end
                            end else begin
                                if ({2'b00, r_ramp_base} <= ramp_floor) begin
                                    n_level = r_level_min;
                                end else begin
                                    n_level = r_ramp_base - key_step[LEVEL_W-1:0];
                                end
                            end
                        end
                    end else if (r_in_press > KEY_LONG) begin
                        n_save = 1'b1;
                    end else if (r_in_press > KEY_SHORT) begin
                        n_on = 1'b0;
                    end
                end else if (!r_in_down && r_in_press > KEY_SHORT && !r_fault) begin
                    n_on = 1'b1;
                end
            end
            OP_SENSOR: begin
                if (r_in_hwf) begin
                    n_fault = 1'b1;
                end else if (r_fault) begin
                    if (r_in_temp < r_temp_low) begin
                        n_fault = 1'b0;
                    end
                end else if (r_in_temp >= r_temp_high) begin
                    n_fault = 1'b1;
                end
            end
            default: begin
                n_save = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_max   <= FULL_LEVEL;
            r_level_min   <= '0;
            r_start_level <= FULL_LEVEL;
            r_temp_high   <= 8'd200;
            r_temp_low    <= 8'd180;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_half_period <= '0;
            r_phase_delay <= '0;
            r_timer_cnt   <= '0;
            r_timer_run   <= 1'b0;
            r_ovf_armed   <= 1'b0;
            r_level       <= FULL_LEVEL;
            r_ramp_base   <= '0;
            r_on          <= 1'b0;
            r_sync_wait   <= 1'b1;
            r_fault       <= 1'b0;
            r_gate        <= 1'b0;
        end else begin
            if (load_in) begin
                r_in_valid <= i_valid;
                r_in_op    <= i_opcode;
                r_in_down  <= i_key_down;
                r_in_press <= i_press_time;
                r_in_hwf   <= i_sensor_fault;
                r_in_temp  <= i_temperature;
            end
            if (advance) begin
                r_half_period <= n_half_period;
                r_phase_delay <= n_phase_delay;
                r_timer_cnt   <= n_timer_cnt;
                r_timer_run   <= n_timer_run;
                r_ovf_armed   <= n_ovf_armed;
                r_level       <= n_level;
                r_ramp_base   <= n_ramp_base;
                r_on          <= n_on;
                r_sync_wait   <= n_sync_wait;
                r_fault       <= n_fault;
                r_gate        <= n_gate;
                r_out_valid   <= 1'b1;
                r_out_gate    <= n_gate;
                r_out_on      <= n_on;
                r_out_sync    <= n_sync_wait;
                r_out_fault   <= n_fault;
                r_out_level   <= n_level;
                r_out_save    <= n_save;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_LEVEL_MAX: r_level_max <= i_cfg_wdata[LEVEL_W-1:0];
                    REG_LEVEL_MIN: r_level_min <= i_cfg_wdata[LEVEL_W-1:0];
                    REG_START_LVL: begin
                        r_start_level <= i_cfg_wdata[LEVEL_W-1:0];
                        r_level       <= i_cfg_wdata[LEVEL_W-1:0];
                    end
                    REG_TEMP_HIGH: r_temp_high <= i_cfg_wdata;
                    REG_TEMP_LOW:  r_temp_low  <= i_cfg_wdata;
                    default: begin
                        r_start_level <= r_start_level;
                    end
                endcase
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_triac_drive   = r_out_gate;
    assign o_is_on         = r_out_on;
    assign o_awaiting_sync = r_out_sync;
    assign o_is_fault      = r_out_fault;
    assign o_current_level = r_out_level;
    assign o_save_request  = r_out_save;

    `PCD_ASSERT_NEXT(a_zc_clears_sync, i_clk, i_rst_n, advance && r_in_op == OP_ZCROSS, !o_awaiting_sync)
    `PCD_ASSERT_SAME(a_save_while_on, i_clk, i_rst_n, o_valid && o_save_request, o_is_on)
    `PCD_ASSERT_NEXT(a_idle_timer_holds, i_clk, i_rst_n, advance && r_in_op == OP_TICK && !r_timer_run, $stable(r_timer_cnt))

endmodule

`default_nettype wire
